/* design/vds_pkg.sv */
// Shared constants and types for the directional vertex shader.
package vds_pkg;

  localparam int NORMAL_BITS    = 24;
  localparam int UNIT_FRAC_BITS = 14;
  localparam int LIGHT_BITS     = 16;
  localparam int COLOR_BITS     = 8;

  localparam int MAG_BITS  = 23;
  localparam int LEN_W     = $clog2(NORMAL_BITS + 1);
  localparam int SQ_BITS   = 2 * MAG_BITS + 2;
  localparam int RAD_BITS  = SQ_BITS + 16;
  localparam int ROOT_BITS = RAD_BITS / 2;
  localparam int REM_W     = ROOT_BITS + 2;
  localparam int QUO_BITS  = UNIT_FRAC_BITS + 2;
  localparam int NUM_BITS  = MAG_BITS + UNIT_FRAC_BITS + 9;
  localparam int DIV_W     = ROOT_BITS + QUO_BITS;
  localparam int UNIT_W    = UNIT_FRAC_BITS + 2;
  localparam int PROD_W    = UNIT_W + LIGHT_BITS;
  localparam int DOT_W     = PROD_W + 2;
  localparam int DFB       = UNIT_FRAC_BITS + 14;
  localparam int ILL_W     = 17;

  localparam logic [ILL_W-1:0] Q16_ONE = 17'h10000;
  localparam logic [15:0] AMB0 = 16'd28836;
  localparam logic [15:0] DIF0 = 16'd36700;
  localparam logic [15:0] AMB1 = 16'd44564;
  localparam logic [15:0] DET1 = 16'd15729;
  localparam logic [15:0] SKY1 = 16'd5243;

  localparam logic [COLOR_BITS-1:0] FIX_RED   = 8'd218;
  localparam logic [COLOR_BITS-1:0] FIX_GREEN = 8'd210;
  localparam logic [COLOR_BITS-1:0] FIX_BLUE  = 8'd210;
  localparam logic [COLOR_BITS-1:0] FIX_ALPHA = 8'd255;

  localparam logic signed [LIGHT_BITS-1:0] LIGHT_X_RST = -16'sd7968;
  localparam logic signed [LIGHT_BITS-1:0] LIGHT_Y_RST = 16'sd14189;
  localparam logic signed [LIGHT_BITS-1:0] LIGHT_Z_RST = 16'sd1903;

  typedef enum logic [1:0] {
    CFG_LIGHT_X = 2'd0,
    CFG_LIGHT_Y = 2'd1,
    CFG_LIGHT_Z = 2'd2
  } cfg_index_t;

  typedef enum logic {
    ACT_SMOOTH    = 1'b0,
    ACT_TWO_SIDED = 1'b1
  } action_t;

  typedef struct packed {
    action_t               action;
    logic [2:0]            neg;
    logic                  zero;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic [COLOR_BITS-1:0] alpha;
  } side_t;

endpackage

/* design/vertex_directional_shader.sv */
// Top level: pipelined Lambert plus ambient vertex shader, with a sky term in two-sided mode.
// Throughput is one vertex per cycle while the output is not held; the 32-stage square root and the
// 16-stage divider are fully pipelined, one result bit per stage.
// The whole pipeline advances together and halts only when the output holds.
// Reset (synchronous, active low) clears all valid bits and loads the light.
module vertex_directional_shader (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,  // normal_x, normal_y, normal_z, base_red, base_green,
                                  // base_blue, base_alpha
  input  logic         in_tuser,  // action
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata, // shaded_red, shaded_green, shaded_blue, shaded_alpha
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int NB     = vds_pkg::NORMAL_BITS;
  localparam int MB     = vds_pkg::MAG_BITS;
  localparam int S_SH   = 2;
  localparam int S_SQ   = 3;
  localparam int S_SUM  = 4;
  localparam int S_RT0  = 5;
  localparam int S_RTL  = S_RT0 + vds_pkg::ROOT_BITS - 1;
  localparam int S_NUM  = S_RTL + 1;
  localparam int S_DV0  = S_NUM + 1;
  localparam int S_DVL  = S_NUM + vds_pkg::QUO_BITS;
  localparam int S_UNIT = S_DVL + 1;
  localparam int S_PROD = S_UNIT + 1;
  localparam int S_TERM = S_PROD + 1;
  localparam int S_WT   = S_TERM + 1;
  localparam int S_ILL  = S_WT + 1;
  localparam int S_CH   = S_ILL + 1;
  localparam int LAST   = S_CH + 1;
  localparam int ACC_W  = vds_pkg::ILL_W + 18;
  localparam int CP_W   = vds_pkg::COLOR_BITS + vds_pkg::ILL_W;
  localparam int SKY_W  = vds_pkg::UNIT_FRAC_BITS + 18;

  logic en;
  logic vld_r [0:LAST];
  vds_pkg::side_t side_r [0:LAST];
  logic signed [vds_pkg::LIGHT_BITS-1:0] light_r [3];

  assign en         = !vld_r[LAST] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAST];
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r[0] <= vds_pkg::LIGHT_X_RST;
      light_r[1] <= vds_pkg::LIGHT_Y_RST;
      light_r[2] <= vds_pkg::LIGHT_Z_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vds_pkg::CFG_LIGHT_X: light_r[0] <= cfg_data;
        vds_pkg::CFG_LIGHT_Y: light_r[1] <= cfg_data;
        vds_pkg::CFG_LIGHT_Z: light_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAST; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k <= LAST; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // Input stage: magnitudes and signs.
  logic [NB-1:0] abs_r [3];
  logic [NB-1:0] abs1_r [3];
  logic [vds_pkg::LEN_W-1:0] len_r;
  logic [NB-1:0] nin [3];
  logic [NB-1:0] mx;
  logic [vds_pkg::LEN_W-1:0] len_c;
  vds_pkg::side_t side_in;

  always_comb begin
    for (int l = 0; l < 3; l++) nin[l] = in_tdata[l*NB +: NB];
    side_in.action = vds_pkg::action_t'(in_tuser);
    for (int l = 0; l < 3; l++) side_in.neg[l] = nin[l][NB-1];
    side_in.zero  = (nin[0] == '0) && (nin[1] == '0) && (nin[2] == '0);
    side_in.red   = in_tdata[3*NB +: 8];
    side_in.green = in_tdata[3*NB+8 +: 8];
    side_in.blue  = in_tdata[3*NB+16 +: 8];
    side_in.alpha = in_tdata[3*NB+24 +: 8];
  end

  always_comb begin
    mx = abs_r[0];
    if (abs_r[1] > mx) mx = abs_r[1];
    if (abs_r[2] > mx) mx = abs_r[2];
    len_c = '0;
    for (int b = 0; b < NB; b++) begin
      if (mx[b]) len_c = vds_pkg::LEN_W'(b + 1);
    end
  end

  // Block shift, squares and sum of squares.
  logic [MB-1:0] mag_r [S_SH:S_NUM][3];
  logic [2*MB-1:0] sq_r [3];
  logic [vds_pkg::RAD_BITS-1:0] rad_r [S_SUM:S_RTL];
  logic [vds_pkg::REM_W-1:0] srem_r [S_RT0:S_RTL];
  logic [vds_pkg::ROOT_BITS-1:0] root_r [S_RT0:S_RTL];

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int k = 1; k <= LAST; k++) side_r[k] <= side_r[k-1];
      for (int l = 0; l < 3; l++) begin
        abs_r[l]  <= nin[l][NB-1] ? (NB)'(-nin[l]) : nin[l];
        abs1_r[l] <= abs_r[l];
        if (32'(len_r) > MB) mag_r[S_SH][l] <= MB'(abs1_r[l] >> (32'(len_r) - MB));
        else mag_r[S_SH][l] <= MB'({{MB{1'b0}}, abs1_r[l]} << (MB - 32'(len_r)));
        for (int k = S_SH + 1; k <= S_NUM; k++) mag_r[k][l] <= mag_r[k-1][l];
        sq_r[l] <= mag_r[S_SQ-1][l] * mag_r[S_SQ-1][l];
      end
      len_r <= len_c;
      rad_r[S_SUM] <= {vds_pkg::SQ_BITS'(sq_r[0]) + vds_pkg::SQ_BITS'(sq_r[1])
                       + vds_pkg::SQ_BITS'(sq_r[2]), 16'b0};
    end
  end

  // Square root, one result bit per stage.
  for (genvar k = S_RT0; k <= S_RTL; k++) begin : g_sqrt
    logic [vds_pkg::REM_W-1:0] rin, rsh, trial;
    logic [vds_pkg::ROOT_BITS-1:0] qin;
    if (k == S_RT0) begin : g_first
      assign rin = '0;
      assign qin = '0;
    end else begin : g_next
      assign rin = srem_r[k-1];
      assign qin = root_r[k-1];
    end
    assign rsh   = {rin[vds_pkg::REM_W-3:0], rad_r[k-1][vds_pkg::RAD_BITS-1 -: 2]};
    assign trial = {qin, 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        if (k < S_RTL) rad_r[k] <= rad_r[k-1] << 2;
        if (rsh >= trial) begin
          srem_r[k] <= rsh - trial;
          root_r[k] <= {qin[vds_pkg::ROOT_BITS-2:0], 1'b1};
        end else begin
          srem_r[k] <= rsh;
          root_r[k] <= {qin[vds_pkg::ROOT_BITS-2:0], 1'b0};
        end
      end
    end
  end

  // Division of each magnitude by the root, one quotient bit per stage.
  logic [vds_pkg::DIV_W-1:0] drem_r [S_NUM:S_DVL][3];
  logic [vds_pkg::ROOT_BITS-1:0] den_r [S_NUM:S_DVL];
  logic [vds_pkg::QUO_BITS-1:0] quo_r [S_DV0:S_DVL][3];

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[S_NUM] <= root_r[S_RTL];
      for (int l = 0; l < 3; l++) begin
        drem_r[S_NUM][l] <= vds_pkg::DIV_W'({mag_r[S_NUM-1][l], {(vds_pkg::UNIT_FRAC_BITS + 8){1'b0}}})
                            + vds_pkg::DIV_W'(root_r[S_RTL] >> 1);
      end
    end
  end

  for (genvar k = S_DV0; k <= S_DVL; k++) begin : g_div
    localparam int SH = S_DVL - k;
    logic [vds_pkg::DIV_W-1:0] dsh;
    assign dsh = vds_pkg::DIV_W'(den_r[k-1]) << SH;
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_r[k-1];
        for (int l = 0; l < 3; l++) begin
          logic [vds_pkg::QUO_BITS-1:0] qprev;
          qprev = (k == S_DV0) ? '0 : quo_r[k == S_DV0 ? S_DV0 : k-1][l];
          if (drem_r[k-1][l] >= dsh) begin
            drem_r[k][l] <= drem_r[k-1][l] - dsh;
            quo_r[k][l]  <= {qprev[vds_pkg::QUO_BITS-2:0], 1'b1};
          end else begin
            drem_r[k][l] <= drem_r[k-1][l];
            quo_r[k][l]  <= {qprev[vds_pkg::QUO_BITS-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Unit normal, dot product and illumination.
  localparam logic [vds_pkg::QUO_BITS-1:0] U_ONE = vds_pkg::QUO_BITS'(1) << vds_pkg::UNIT_FRAC_BITS;
  localparam logic [vds_pkg::DOT_W-1:0] D_ONE = vds_pkg::DOT_W'(1) << vds_pkg::DFB;

  logic signed [vds_pkg::UNIT_W-1:0] u_r [3];
  logic signed [vds_pkg::PROD_W-1:0] p_r [3];
  logic signed [vds_pkg::UNIT_W-1:0] uy_r;
  logic [vds_pkg::ILL_W-1:0] t_r, sky_r, ill_r;
  logic [32:0] wa_r, ws_r;
  logic [15:0] amb_r;
  logic [CP_W-1:0] cp_r [3];
  logic [7:0] out_r [4];

  logic signed [vds_pkg::DOT_W-1:0] dsum;
  logic [vds_pkg::DOT_W-1:0] dmag;
  logic [vds_pkg::DOT_W:0] tsum;
  logic [SKY_W-1:0] skysum;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-17:0] ill_c;
  logic [7:0] chan [3];

  always_comb begin
    dsum = vds_pkg::DOT_W'(p_r[0]) + vds_pkg::DOT_W'(p_r[1]) + vds_pkg::DOT_W'(p_r[2]);
    if (side_r[S_TERM-1].action == vds_pkg::ACT_TWO_SIDED) begin
      dmag = dsum[vds_pkg::DOT_W-1] ? vds_pkg::DOT_W'(-dsum) : vds_pkg::DOT_W'(dsum);
    end else begin
      dmag = dsum[vds_pkg::DOT_W-1] ? '0 : vds_pkg::DOT_W'(dsum);
    end
    if (dmag > D_ONE) dmag = D_ONE;
    tsum = ({1'b0, dmag} + ((vds_pkg::DOT_W + 1)'(1) << (vds_pkg::DFB - 17)))
           >> (vds_pkg::DFB - 16);
    skysum = uy_r[vds_pkg::UNIT_W-1] ? '0 :
             ((SKY_W'(uy_r) << 16) + (SKY_W'(1) << (vds_pkg::UNIT_FRAC_BITS - 1)))
             >> vds_pkg::UNIT_FRAC_BITS;
    acc = {amb_r, 16'b0} + ACC_W'(wa_r) + ACC_W'(ws_r) + ACC_W'(32768);
    ill_c = acc[ACC_W-1:16];
    for (int l = 0; l < 3; l++) begin
      logic [CP_W-1:0] rnd;
      rnd = (cp_r[l] + CP_W'(32768)) >> 16;
      chan[l] = (rnd > CP_W'(255)) ? 8'd255 : rnd[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        logic [vds_pkg::QUO_BITS-1:0] qc;
        qc = (quo_r[S_DVL][l] > U_ONE) ? U_ONE : quo_r[S_DVL][l];
        if (side_r[S_UNIT-1].zero) u_r[l] <= (l == 1) ? $signed(U_ONE) : '0;
        else if (side_r[S_UNIT-1].neg[l]) u_r[l] <= -$signed(qc);
        else u_r[l] <= $signed(qc);
        p_r[l] <= u_r[l] * light_r[l];
      end
      uy_r <= u_r[1];
      t_r <= tsum[vds_pkg::ILL_W-1:0];
      sky_r <= skysum[vds_pkg::ILL_W-1:0];
      if (side_r[S_WT-1].action == vds_pkg::ACT_TWO_SIDED) begin
        wa_r  <= 33'(vds_pkg::DET1 * t_r);
        ws_r  <= 33'(vds_pkg::SKY1 * sky_r);
        amb_r <= vds_pkg::AMB1;
      end else begin
        wa_r  <= 33'(vds_pkg::DIF0 * t_r);
        ws_r  <= '0;
        amb_r <= vds_pkg::AMB0;
      end
      ill_r <= (ill_c > (ACC_W - 16)'(vds_pkg::Q16_ONE)) ? vds_pkg::Q16_ONE
             : ill_c[vds_pkg::ILL_W-1:0];
      if (side_r[S_CH-1].action == vds_pkg::ACT_TWO_SIDED) begin
        cp_r[0] <= vds_pkg::FIX_RED * ill_r;
        cp_r[1] <= vds_pkg::FIX_GREEN * ill_r;
        cp_r[2] <= vds_pkg::FIX_BLUE * ill_r;
      end else begin
        cp_r[0] <= side_r[S_CH-1].red * ill_r;
        cp_r[1] <= side_r[S_CH-1].green * ill_r;
        cp_r[2] <= side_r[S_CH-1].blue * ill_r;
      end
      for (int l = 0; l < 3; l++) out_r[l] <= chan[l];
      out_r[3] <= (side_r[LAST-1].action == vds_pkg::ACT_TWO_SIDED) ? vds_pkg::FIX_ALPHA
                : side_r[LAST-1].alpha;
    end
  end

  assign out_tdata = {out_r[3], out_r[2], out_r[1], out_r[0]};

  a_ill_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[S_ILL] |-> ill_r <= vds_pkg::Q16_ONE)
    else $error("illumination above one");

  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[S_RTL] && !side_r[S_RTL].zero) |-> root_r[S_RTL][vds_pkg::ROOT_BITS-1 -: 2] != 2'b00)
    else $error("root of a nonzero normal out of range");

  a_zero_up: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[S_UNIT] && side_r[S_UNIT].zero) |-> (u_r[1] == $signed(U_ONE) && u_r[0] == '0))
    else $error("zero normal not turned straight up");

  a_fixed_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[LAST] && side_r[LAST].action == vds_pkg::ACT_TWO_SIDED) |-> out_r[3] == 8'd255)
    else $error("two-sided alpha is not opaque");

endmodule
